@@ rtl/core/gmig_pkg.sv @@
// gmig_pkg: shared types and constants of the grid mesh index generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gmig_pkg;

    localparam int GRID_W     = 11;
    localparam int CACHE_W    = 7;
    localparam int INDEX_W    = 21;
    localparam int PROD_W     = 2 * GRID_W;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int MAX_GRID   = 1024;
    localparam int MIN_CACHE  = 3;

    localparam logic REG_GRID_SIZE  = 1'b0;
    localparam logic REG_CACHE_SIZE = 1'b1;

    typedef logic [GRID_W-1:0]  grid_t;
    typedef logic [CACHE_W-1:0] cache_t;
    typedef logic [INDEX_W-1:0] index_t;

    // one triangle as decided by the front end
    typedef struct packed {
        grid_t row;
        grid_t col;
        grid_t stride;
        logic  priming;
        logic  second_half;
        logic  last;
    } desc_t;

    typedef struct packed {
        index_t index_a;
        index_t index_b;
        index_t index_c;
        logic   priming;
        logic   last;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/core/gmig_front.sv @@
// gmig_front: strip/row/column walker, turns each accepted beat into a
// triangle descriptor unless the walk is finished. Depends on gmig_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gmig_front
    import gmig_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   accept,
    input  wire logic   restart,
    input  wire grid_t  grid_size,
    input  wire cache_t cache_size,
    output logic        desc_valid,
    output desc_t       desc
);

    typedef struct packed {
        grid_t left;
        grid_t right;
        grid_t row;
        grid_t col;
        logic  second_half;
        logic  in_priming;
        logic  finished;
    } walk_t;

    localparam walk_t WALK_IDLE = '{
        left: '0, right: '0, row: '0, col: '0,
        second_half: 1'b0, in_priming: 1'b0, finished: 1'b1
    };

    walk_t walk_reg;
    walk_t walk_next;

    grid_t  g;
    cache_t c;
    walk_t  cur;
    walk_t  adv;

    function automatic walk_t begin_strip(input walk_t s, input grid_t left,
                                          input grid_t gs, input cache_t cs);
        walk_t n;
        logic [GRID_W:0]   span;
        logic [GRID_W:0]   right;
        logic [GRID_W:0]   w;
        logic [GRID_W+1:0] w2;
        n = s;
        span = {1'b0, gs} - {1'b0, left};
        if ((left < gs) && (span >= ({{(GRID_W+1-CACHE_W){1'b0}}, cs} - 1'b1)))
        begin
            right = {1'b0, left} + {{(GRID_W+1-CACHE_W){1'b0}}, cs} - 2'd2;
        end
        else
        begin
            right = {1'b0, gs};
        end
        w  = (right > {1'b0, left}) ? (right - {1'b0, left}) : '0;
        w2 = {w, 1'b0} + 1'b1;
        n.left        = left;
        n.right       = right[GRID_W-1:0];
        n.in_priming  = w2 > {{(GRID_W+2-CACHE_W){1'b0}}, cs};
        n.col         = left;
        n.row         = '0;
        n.second_half = 1'b0;
        return n;
    endfunction

    function automatic walk_t advance(input walk_t s, input grid_t gs, input cache_t cs);
        walk_t n;
        logic [GRID_W:0] col_inc;
        logic [GRID_W:0] row_inc;
        n = s;
        col_inc = {1'b0, s.col} + 1'b1;
        row_inc = {1'b0, s.row} + 1'b1;
        if (s.in_priming)
        begin
            if (col_inc >= {1'b0, s.right})
            begin
                n.in_priming = 1'b0;
                n.col        = s.left;
                n.row        = '0;
            end
            else
            begin
                n.col = col_inc[GRID_W-1:0];
            end
        end
        else if (!s.second_half)
        begin
            n.second_half = 1'b1;
        end
        else
        begin
            n.second_half = 1'b0;
            if (col_inc < {1'b0, s.right})
            begin
                n.col = col_inc[GRID_W-1:0];
            end
            else
            begin
                n.col = s.left;
                if (row_inc < {1'b0, gs})
                begin
                    n.row = row_inc[GRID_W-1:0];
                end
                else if (s.right >= gs)
                begin
                    n.finished = 1'b1;
                end
                else
                begin
                    n = begin_strip(n, s.right, gs, cs);
                end
            end
        end
        return n;
    endfunction

    always_comb
    begin
        g = (grid_size > grid_t'(MAX_GRID)) ? grid_t'(MAX_GRID) : grid_size;
        c = (cache_size < cache_t'(MIN_CACHE)) ? cache_t'(MIN_CACHE) : cache_size;
        cur = walk_reg;
        if (restart)
        begin
            if (g == '0)
            begin
                cur.finished = 1'b1;
            end
            else
            begin
                cur = begin_strip(walk_reg, '0, g, c);
                cur.finished = 1'b0;
            end
        end
        adv = advance(cur, g, c);
        walk_next = cur.finished ? cur : adv;

        desc_valid       = accept && !cur.finished;
        desc.row         = cur.row;
        desc.col         = cur.col;
        desc.stride      = g + 1'b1;
        desc.priming     = cur.in_priming;
        desc.second_half = cur.second_half;
        desc.last        = adv.finished;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= WALK_IDLE;
        end
        else if (accept)
        begin
            walk_reg <= walk_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/gmig_desc_queue.sv @@
// gmig_desc_queue: two-entry descriptor queue between front and back end.
// Depends on gmig_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gmig_desc_queue
    import gmig_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire desc_t wr_data,
    output logic       full,
    input  wire logic  rd_en,
    output logic       not_empty,
    output desc_t      rd_data
);

    desc_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/gmig_back.sv @@
// gmig_back: row-base multiply, index adders and two-entry result queue.
// Depends on gmig_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gmig_back
    import gmig_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  desc_avail,
    input  wire desc_t desc,
    output logic       desc_take,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    // multiply stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [PROD_W-1:0] top_reg;
    desc_t             s1_desc_reg;

    // result queue
    result_t     out_mem_reg [2];
    logic        out_wr_reg;
    logic        out_rd_reg;
    logic [1:0]  out_cnt_reg;
    logic [1:0]  out_cnt_next;

    logic        pop_ok;
    logic        s1_move;
    logic [PROD_W:0] base;
    logic [PROD_W:0] below;
    result_t     res;

    assign pop_ok    = pop && (out_cnt_reg != 2'd0);
    assign s1_move   = s1_valid_reg && ((out_cnt_reg != 2'd2) || pop_ok);
    assign desc_take = desc_avail && (!s1_valid_reg || s1_move);
    assign empty     = (out_cnt_reg == 2'd0);
    assign result    = out_mem_reg[out_rd_reg];

    always_comb
    begin
        base  = {1'b0, top_reg} + {{(PROD_W+1-GRID_W){1'b0}}, s1_desc_reg.col};
        below = base + {{(PROD_W+1-GRID_W){1'b0}}, s1_desc_reg.stride};
        if (s1_desc_reg.priming)
        begin
            res.index_a = base[INDEX_W-1:0];
            res.index_b = base[INDEX_W-1:0];
            res.index_c = base[INDEX_W-1:0] + 1'b1;
        end
        else if (!s1_desc_reg.second_half)
        begin
            res.index_a = base[INDEX_W-1:0];
            res.index_b = below[INDEX_W-1:0];
            res.index_c = base[INDEX_W-1:0] + 1'b1;
        end
        else
        begin
            res.index_a = base[INDEX_W-1:0] + 1'b1;
            res.index_b = below[INDEX_W-1:0];
            res.index_c = below[INDEX_W-1:0] + 1'b1;
        end
        res.priming = s1_desc_reg.priming;
        res.last    = s1_desc_reg.last;

        s1_valid_next = desc_take || (s1_valid_reg && !s1_move);
        out_cnt_next  = out_cnt_reg + {1'b0, s1_move} - {1'b0, pop_ok};
    end

    always_ff @(posedge clk)
    begin
        if (desc_take)
        begin
            top_reg     <= desc.row * desc.stride;
            s1_desc_reg <= desc;
        end
        if (s1_move)
        begin
            out_mem_reg[out_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_wr_reg   <= 1'b0;
            out_rd_reg   <= 1'b0;
            out_cnt_reg  <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_wr_reg   <= out_wr_reg ^ s1_move;
            out_rd_reg   <= out_rd_reg ^ pop_ok;
            out_cnt_reg  <= out_cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/grid_mesh_index_generator.sv @@
// grid_mesh_index_generator: top level, register port and block wiring.
// Depends on gmig_pkg, gmig_front, gmig_desc_queue, gmig_back.
// Throughput: one beat per cycle while the queue is not full; a beat passes
// the descriptor queue, row*stride multiply register and result queue in turn.
// Reset: grid_size 1, cache_size 8, walker idle until a restart beat; queues empty.
`timescale 1ns / 1ps
`default_nettype none
module grid_mesh_index_generator
    import gmig_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              restart,
    output logic                   empty,
    input  wire logic              pop,
    output index_t                 index_a,
    output index_t                 index_b,
    output index_t                 index_c,
    output logic                   is_priming,
    output logic                   is_last
);

    grid_t   grid_size_reg;
    cache_t  cache_size_reg;
    logic    cfg_wr;
    logic    accept;
    logic    desc_valid;
    desc_t   desc_in;
    desc_t   desc_out;
    logic    desc_avail;
    logic    desc_take;
    result_t result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = push && !full;

    always_comb
    begin
        case (paddr[2])
            REG_GRID_SIZE:  prdata = {{(DATA_W-GRID_W){1'b0}}, grid_size_reg};
            REG_CACHE_SIZE: prdata = {{(DATA_W-CACHE_W){1'b0}}, cache_size_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= grid_t'(1);
            cache_size_reg <= cache_t'(8);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_GRID_SIZE)
            begin
                grid_size_reg <= pwdata[GRID_W-1:0];
            end
            else
            begin
                cache_size_reg <= pwdata[CACHE_W-1:0];
            end
        end
    end

    gmig_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .restart    (restart),
        .grid_size  (grid_size_reg),
        .cache_size (cache_size_reg),
        .desc_valid (desc_valid),
        .desc       (desc_in)
    );

    gmig_desc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (desc_valid),
        .wr_data   (desc_in),
        .full      (full),
        .rd_en     (desc_take),
        .not_empty (desc_avail),
        .rd_data   (desc_out)
    );

    gmig_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_avail (desc_avail),
        .desc       (desc_out),
        .desc_take  (desc_take),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign index_a    = result.index_a;
    assign index_b    = result.index_b;
    assign index_c    = result.index_c;
    assign is_priming = result.priming;
    assign is_last    = result.last;

endmodule
`default_nettype wire
